@@ hw/rtl/cst_pkg.sv @@
// Shared types and constants of the counting semaphore table.
// No dependencies; every other file of the block imports this package.
package cst_pkg;

   localparam int NUM_SEMS_DEF    = 16;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 16;
   localparam int PID_W    = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CREATE  = 2'd0,
      ACT_DESTROY = 2'd1,
      ACT_WAIT    = 2'd2,
      ACT_SIGNAL  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_EXISTS  = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EXEC
   } seq_state_type;

endpackage

@@ hw/rtl/cst_if.sv @@
// Valid/ready channel interfaces for the request and response beats.
// Depends on cst_pkg for the field widths.
interface cst_req_if import cst_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [INDEX_W-1:0]         sem_index;
   logic signed [COUNT_W-1:0]  init_value;
   logic [PID_W-1:0]           pid;

   modport source (output valid, action, sem_index, init_value, pid, input ready);
   modport sink   (input valid, action, sem_index, init_value, pid, output ready);
endinterface

interface cst_rsp_if import cst_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic                       blocked;
   logic                       woke;
   logic [PID_W-1:0]           woken_pid;
   logic signed [COUNT_W-1:0]  count_after;

   modport source (output valid, status, blocked, woke, woken_pid, count_after,
                   input ready);
   modport sink   (input valid, status, blocked, woke, woken_pid, count_after,
                   output ready);
endinterface

@@ hw/rtl/counting_semaphore_table_top.sv @@
// Top level of the counting semaphore table: sequencer, slot memory,
// waiter memory and response register. Depends on cst_pkg and cst_if.
//
// A table of NUM_SEMS counting semaphores, each with a FIFO of up to
// QUEUE_DEPTH waiting process ids, addressed by slot index. Every request
// beat (create, destroy, wait, signal) produces exactly one response beat.
// The block handles one request at a time: the cycle in which a request
// is accepted also reads the slot memory, the next cycle reads the waiter
// memory at the queue head, and the execute step updates both memories
// through the shared saturating add/subtract unit and loads the response
// register, which then offers the response beat. The request side is ready
// again on the cycle after the response is loaded. The block takes no new
// request until it is through with the last; the two registered memory
// reads that one request needs in sequence keep it busy. If the response
// register is still occupied, the update waits until it is taken. Counts
// saturate at -32768 and 32767. Slot state is created empty; no clearing
// pass is needed after reset because only the valid bits are reset and
// the memory contents are used only behind a valid slot.
module counting_semaphore_table_top
   import cst_pkg::*;
#(
   parameter int NUM_SEMS    = NUM_SEMS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   cst_req_if.sink    req_ch,
   cst_rsp_if.source  rsp_ch
);

   localparam int SLOT_AW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int HEAD_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W    = ((HEAD_W > FILL_W) ? HEAD_W : FILL_W) + 1;
   localparam int WAIT_N   = NUM_SEMS * QUEUE_DEPTH;
   localparam int WAIT_AW  = (WAIT_N > 1) ? $clog2(WAIT_N) : 1;

   // Slot state memories, addressed together by slot, and the waiter memory.
   logic signed [COUNT_W-1:0] count_mem [NUM_SEMS];
   logic [HEAD_W-1:0]         head_mem  [NUM_SEMS];
   logic [FILL_W-1:0]         fill_mem  [NUM_SEMS];
   logic [PID_W-1:0]          waiter_mem [WAIT_N];

   logic [NUM_SEMS-1:0]       slot_valid_ff, slot_valid_in;

   seq_state_type             state_ff, state_in;

   // Latched request.
   action_type                action_ff;
   logic [SLOT_AW-1:0]        slot_ff;
   logic                      in_range_ff;
   logic signed [COUNT_W-1:0] init_ff;
   logic [PID_W-1:0]          pid_ff;

   // Registered memory read data.
   logic signed [COUNT_W-1:0] count_rd_ff;
   logic [HEAD_W-1:0]         head_rd_ff;
   logic [FILL_W-1:0]         fill_rd_ff;
   logic [PID_W-1:0]          waiter_rd_ff;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff;
   logic                      blocked_ff, woke_ff;
   logic [PID_W-1:0]          woken_pid_ff;
   logic signed [COUNT_W-1:0] count_after_ff;

   logic                      req_accept;
   logic                      out_load;
   logic                      seq_ready;

   // Datapath results of the execute cycle.
   status_type                status_c;
   logic                      blocked_c, woke_c;
   logic [PID_W-1:0]          woken_pid_c;
   logic signed [COUNT_W-1:0] count_after_c;
   logic                      slot_wr_c, waiter_wr_c;
   logic signed [COUNT_W-1:0] count_wr_c;
   logic [HEAD_W-1:0]         head_wr_c;
   logic [FILL_W-1:0]         fill_wr_c;
   logic                      valid_set_c, valid_clr_c;

   logic                      slot_valid_c;
   logic [COUNT_W:0]          sum_c;
   logic signed [COUNT_W-1:0] count_next_c;
   logic [POS_W-1:0]          tail_sum_c, head_sum_c;
   logic [HEAD_W-1:0]         tail_pos_c, head_next_c;
   logic [WAIT_AW-1:0]        wait_base_c;

   assign req_accept   = req_ch.valid && seq_ready;
   assign req_ch.ready = seq_ready;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_ch.valid) begin
               state_in = SEQ_READ;
            end
         end
         SEQ_READ: begin
            state_in = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      seq_ready = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            seq_ready = 1'b1;
         end
         SEQ_READ: begin
         end
         SEQ_EXEC: begin
            out_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // Request capture and slot memory read
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         action_ff   <= action_type'(req_ch.action);
         slot_ff     <= SLOT_AW'(req_ch.sem_index);
         in_range_ff <= 32'(req_ch.sem_index) < NUM_SEMS;
         init_ff     <= req_ch.init_value;
         pid_ff      <= req_ch.pid;
         count_rd_ff <= count_mem[SLOT_AW'(req_ch.sem_index)];
         head_rd_ff  <= head_mem[SLOT_AW'(req_ch.sem_index)];
         fill_rd_ff  <= fill_mem[SLOT_AW'(req_ch.sem_index)];
      end
   end

   // Queue positions: head + fill stays below twice the depth, so one
   // compare and subtract wraps it.
   assign wait_base_c = WAIT_AW'(slot_ff) * WAIT_AW'(QUEUE_DEPTH);
   assign tail_sum_c  = POS_W'(head_rd_ff) + POS_W'(fill_rd_ff);
   assign tail_pos_c  = (tail_sum_c >= POS_W'(QUEUE_DEPTH))
                        ? HEAD_W'(tail_sum_c - POS_W'(QUEUE_DEPTH))
                        : HEAD_W'(tail_sum_c);
   assign head_sum_c  = POS_W'(head_rd_ff) + POS_W'(1);
   assign head_next_c = (head_sum_c >= POS_W'(QUEUE_DEPTH))
                        ? '0 : HEAD_W'(head_sum_c);

   // Waiter memory: read at the queue head during the read cycle, write the
   // new tail entry when a wait blocks.
   always_ff @(posedge clock) begin
      if (state_ff == SEQ_READ) begin
         waiter_rd_ff <= waiter_mem[wait_base_c + WAIT_AW'(head_rd_ff)];
      end
      if (out_load && waiter_wr_c) begin
         waiter_mem[wait_base_c + WAIT_AW'(tail_pos_c)] <= pid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && slot_wr_c) begin
         count_mem[slot_ff] <= count_wr_c;
         head_mem[slot_ff]  <= head_wr_c;
         fill_mem[slot_ff]  <= fill_wr_c;
      end
   end

   // ------------------------------------------------------------------
   // Shared saturating add/subtract unit
   // ------------------------------------------------------------------
   assign sum_c = {count_rd_ff[COUNT_W-1], count_rd_ff}
                  + ((action_ff == ACT_WAIT) ? {(COUNT_W+1){1'b1}}
                                             : (COUNT_W+1)'(1));
   // Overflow shows as a mismatch of the two top bits; the count then holds.
   assign count_next_c = (sum_c[COUNT_W] != sum_c[COUNT_W-1])
                         ? count_rd_ff : COUNT_W'(sum_c);

   assign slot_valid_c = in_range_ff && slot_valid_ff[slot_ff];

   always_comb begin
      status_c      = ST_OK;
      blocked_c     = 1'b0;
      woke_c        = 1'b0;
      woken_pid_c   = '0;
      count_after_c = '0;
      slot_wr_c     = 1'b0;
      waiter_wr_c   = 1'b0;
      count_wr_c    = count_next_c;
      head_wr_c     = head_rd_ff;
      fill_wr_c     = fill_rd_ff;
      valid_set_c   = 1'b0;
      valid_clr_c   = 1'b0;
      if (!in_range_ff) begin
         status_c = ST_MISSING;
      end else if (action_ff == ACT_CREATE) begin
         if (slot_valid_c) begin
            status_c      = ST_EXISTS;
            count_after_c = count_rd_ff;
         end else begin
            valid_set_c   = 1'b1;
            slot_wr_c     = 1'b1;
            count_wr_c    = init_ff;
            head_wr_c     = '0;
            fill_wr_c     = '0;
            count_after_c = init_ff;
         end
      end else if (!slot_valid_c) begin
         status_c = ST_MISSING;
      end else begin
         case (action_ff)
            ACT_DESTROY: begin
               valid_clr_c = 1'b1;
            end
            ACT_WAIT: begin
               if (count_next_c[COUNT_W-1]) begin
                  if (fill_rd_ff >= FILL_W'(QUEUE_DEPTH)) begin
                     status_c      = ST_FULL;
                     count_after_c = count_rd_ff;
                  end else begin
                     slot_wr_c     = 1'b1;
                     waiter_wr_c   = 1'b1;
                     fill_wr_c     = fill_rd_ff + FILL_W'(1);
                     blocked_c     = 1'b1;
                     count_after_c = count_next_c;
                  end
               end else begin
                  slot_wr_c     = 1'b1;
                  count_after_c = count_next_c;
               end
            end
            ACT_SIGNAL: begin
               slot_wr_c     = 1'b1;
               count_after_c = count_next_c;
               if ((count_next_c[COUNT_W-1] || count_next_c == '0)
                   && fill_rd_ff != '0) begin
                  head_wr_c   = head_next_c;
                  fill_wr_c   = fill_rd_ff - FILL_W'(1);
                  woke_c      = 1'b1;
                  woken_pid_c = waiter_rd_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Valid bits per slot; destroy need not clear the queue pointers since
   // create rewrites them.
   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (out_load && valid_set_c) begin
         slot_valid_in[slot_ff] = 1'b1;
      end
      if (out_load && valid_clr_c) begin
         slot_valid_in[slot_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         status_ff      <= status_c;
         blocked_ff     <= blocked_c;
         woke_ff        <= woke_c;
         woken_pid_ff   <= woken_pid_c;
         count_after_ff <= count_after_c;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.blocked     = blocked_ff;
   assign rsp_ch.woke        = woke_ff;
   assign rsp_ch.woken_pid   = woken_pid_ff;
   assign rsp_ch.count_after = count_after_ff;

endmodule

@@ hw/rtl/cst_checker.sv @@
// Port-level checker for the counting semaphore table and its bind.
// Depends on cst_pkg; attaches to counting_semaphore_table_top.
module cst_checker
   import cst_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic                      rsp_blocked,
   input logic                      rsp_woke,
   input logic signed [COUNT_W-1:0] rsp_count_after
);

   // A stalled response beat keeps its status and count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count_after)
                                  && $stable(rsp_status))
      else $error("response beat changed while stalled");

   // One request at a time: no request is taken right after another.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A fresh response is only produced while the request side is busy.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without a request in flight");

   // Blocking and waking exclude each other and need a successful action.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_blocked || rsp_woke) |->
         !(rsp_blocked && rsp_woke) && rsp_status == ST_OK)
      else $error("blocked/woke flags inconsistent");

   // A blocked caller always leaves a negative count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blocked |-> rsp_count_after < 0)
      else $error("blocked with non-negative count");

endmodule

bind counting_semaphore_table_top cst_checker u_cst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_blocked     (rsp_ch.blocked),
   .rsp_woke        (rsp_ch.woke),
   .rsp_count_after (rsp_ch.count_after)
);

@@ sim/cst_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the counting semaphore table. It watches both channels,
// predicts each response from its own copy of the table and compares fields.
// Depends on cst_pkg and on the channel interfaces in cst_if.
module cst_result_checker
   import cst_pkg::*;
(
   input  logic clock,
   input  logic reset,
   cst_req_if   req_mon,
   cst_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked,
   output int   blocked_seen,
   output int   woke_seen,
   output int   full_seen
);

   localparam int MAX_REPORTS = 20;
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;

   typedef struct packed {
      status_type                status;
      logic                      blocked;
      logic                      woke;
      logic [PID_W-1:0]          woken_pid;
      logic signed [COUNT_W-1:0] count_after;
   } sem_result_type;

   bit                        slot_live   [NUM_SEMS_DEF];
   logic signed [COUNT_W-1:0] slot_count  [NUM_SEMS_DEF];
   int                        wait_head   [NUM_SEMS_DEF];
   int                        wait_fill   [NUM_SEMS_DEF];
   logic [PID_W-1:0]          waiting_pid [NUM_SEMS_DEF][QUEUE_DEPTH_DEF];

   sem_result_type awaited_responses [$];
   int n_fail;
   int n_checked;
   int n_blocked;
   int n_woke;
   int n_full;

   // Applies one action to the local table and returns the response it earns.
   function automatic sem_result_type execute_action(input action_type act, input int idx,
         input logic signed [COUNT_W-1:0] init, input logic [PID_W-1:0] pid);
      sem_result_type res;
      logic signed [COUNT_W-1:0] cur;
      logic signed [COUNT_W-1:0] nxt;
      res = '0;
      res.status = ST_OK;
      if (idx >= NUM_SEMS_DEF) begin
         res.status = ST_MISSING;
      end else if (act == ACT_CREATE) begin
         if (slot_live[idx]) begin
            res.status = ST_EXISTS;
            res.count_after = slot_count[idx];
         end else begin
            slot_live[idx] = 1'b1;
            slot_count[idx] = init;
            wait_head[idx] = 0;
            wait_fill[idx] = 0;
            res.count_after = init;
         end
      end else if (!slot_live[idx]) begin
         res.status = ST_MISSING;
      end else if (act == ACT_DESTROY) begin
         slot_live[idx] = 1'b0;
         wait_head[idx] = 0;
         wait_fill[idx] = 0;
      end else if (act == ACT_WAIT) begin
         cur = slot_count[idx];
         nxt = (cur == COUNT_MIN) ? cur : cur - 16'sd1;
         if (nxt < 0) begin
            if (wait_fill[idx] >= QUEUE_DEPTH_DEF) begin
               res.status = ST_FULL;
               res.count_after = cur;
            end else begin
               waiting_pid[idx][(wait_head[idx] + wait_fill[idx]) % QUEUE_DEPTH_DEF] = pid;
               wait_fill[idx]++;
               slot_count[idx] = nxt;
               res.blocked = 1'b1;
               res.count_after = nxt;
            end
         end else begin
            slot_count[idx] = nxt;
            res.count_after = nxt;
         end
      end else begin
         cur = slot_count[idx];
         nxt = (cur == COUNT_MAX) ? cur : cur + 16'sd1;
         slot_count[idx] = nxt;
         res.count_after = nxt;
         if (nxt <= 0 && wait_fill[idx] > 0) begin
            res.woke = 1'b1;
            res.woken_pid = waiting_pid[idx][wait_head[idx]];
            wait_head[idx] = (wait_head[idx] + 1) % QUEUE_DEPTH_DEF;
            wait_fill[idx]--;
         end
      end
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
         input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         n_fail++;
         if (n_fail <= MAX_REPORTS) begin
            $display("t=%0t %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      sem_result_type want;
      if (reset) begin
         awaited_responses.delete();
         for (int i = 0; i < NUM_SEMS_DEF; i++) begin
            slot_live[i] = 1'b0;
            wait_head[i] = 0;
            wait_fill[i] = 0;
         end
      end else begin
         // The response side goes first: a response never belongs to a
         // request taken at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            n_checked++;
            if (awaited_responses.size() == 0) begin
               n_fail++;
               if (n_fail <= MAX_REPORTS) begin
                  $display("t=%0t response beat with nothing expected: status %0d count %0d",
                           $time, rsp_mon.status, rsp_mon.count_after);
               end
            end else begin
               want = awaited_responses.pop_front();
               check_field("status", COUNT_W'(want.status), COUNT_W'(rsp_mon.status));
               check_field("blocked", COUNT_W'(want.blocked), COUNT_W'(rsp_mon.blocked));
               check_field("woke", COUNT_W'(want.woke), COUNT_W'(rsp_mon.woke));
               check_field("woken_pid", COUNT_W'(want.woken_pid),
                           COUNT_W'(rsp_mon.woken_pid));
               check_field("count_after", want.count_after, rsp_mon.count_after);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want = execute_action(action_type'(req_mon.action), int'(req_mon.sem_index),
                                  req_mon.init_value, req_mon.pid);
            if (want.blocked) n_blocked++;
            if (want.woke) n_woke++;
            if (want.status == ST_FULL) n_full++;
            awaited_responses.push_back(want);
         end
      end
      fail_count   <= n_fail;
      pending      <= awaited_responses.size();
      checked      <= n_checked;
      blocked_seen <= n_blocked;
      woke_seen    <= n_woke;
      full_seen    <= n_full;
   end

endmodule

@@ sim/tb_counting_semaphore_table_top.sv @@
`timescale 1ns / 100ps
// Testbench top of the counting semaphore table: clock, reset, request
// stimulus, response back-pressure, watchdog and the final verdict.
// Depends on cst_pkg, cst_if, counting_semaphore_table_top and cst_result_checker.
module tb_counting_semaphore_table_top
   import cst_pkg::*;
;

   // Number of request beats to send, and how many at the end go without idling.
   localparam int ITEM_TARGET     = 1150;
   localparam int TAIL_ITEMS      = 120;
   // The long receiver hold-off, and the point in the run where it happens.
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PRESSURE_AT     = 300;
   // Cycles without any accepted beat before the run is declared hung. The
   // slowest legal gap is the hold-off above.
   localparam int STALL_LIMIT     = 4000;
   // Settle time at the end, once no response is pending.
   localparam int DRAIN_CYCLES    = 12;

   logic clock;
   logic reset;

   cst_req_if req_ch ();
   cst_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int checked;
   int blocked_seen;
   int woke_seen;
   int full_seen;

   // Idling controls: percent chance of a gap before a request beat, and
   // percent chance per cycle that the receiver starts a stall burst.
   int sender_idle_pct;
   int sink_idle_pct;
   bit hold_off_req;
   bit hold_off_served;

   int items_sent;
   int sent_per_action [4];
   int stall_cycles;

   counting_semaphore_table_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cst_result_checker result_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked),
      .blocked_seen (blocked_seen),
      .woke_seen    (woke_seen),
      .full_seen    (full_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: counts cycles in which neither channel moves a beat. The
   // counter uses a nonblocking update so the reader below always sees the
   // value from before the edge.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : watchdog
      @(posedge clock);
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("counting_semaphore_table_top: mismatch");
      $finish;
   end

   // Response side. Ready changes only at the falling edge, once per edge.
   // Stall bursts start at random; the one long hold-off is requested
   // by the stimulus process and counted down here.
   initial begin : response_sink
      int stall_left;
      rsp_ch.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_off_req && !hold_off_served) begin
            // The response register stays occupied, so the block stops taking
            // requests while the sender keeps offering them.
            hold_off_served = 1'b1;
            stall_left = HOLD_OFF_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Count values that favor the saturation limits and the zero crossing.
   function automatic logic signed [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return COUNT_W'($urandom_range(0, 6) - 3);
         3: return COUNT_W'(16'sh7fff - $urandom_range(0, 7));
         4: return COUNT_W'(16'sh8000 + $urandom_range(0, 7));
         default: return COUNT_W'($urandom);
      endcase
   endfunction

   function automatic int pick_pct(input int mid, input int high);
      case ($urandom_range(0, 2))
         0: return 0;
         1: return mid;
         default: return high;
      endcase
   endfunction

   // Sends one request beat, with an optional idle burst in front of it.
   // Fields carry junk while valid is low; the block must ignore them.
   task automatic issue_request(input action_type act, input logic [INDEX_W-1:0] idx,
         input logic signed [COUNT_W-1:0] init, input logic [PID_W-1:0] pid);
      int gap;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         gap = $urandom_range(1, 14);
         repeat (gap) begin
            @(negedge clock);
            req_ch.valid      <= 1'b0;
            req_ch.action     <= ACTION_W'($urandom);
            req_ch.sem_index  <= INDEX_W'($urandom);
            req_ch.init_value <= COUNT_W'($urandom);
            req_ch.pid        <= PID_W'($urandom);
         end
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.sem_index  <= idx;
      req_ch.init_value <= init;
      req_ch.pid        <= pid;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      sent_per_action[int'(act)]++;
   endtask

   // One random episode on one slot. Most episodes are meaningful sequences
   // (create, then runs of waits or signals) so that queues fill up, wrap
   // around, overflow and drain; the rest are single actions.
   task automatic run_scenario();
      logic [INDEX_W-1:0] idx;
      action_type act;
      int n;
      idx = INDEX_W'($urandom_range(0, NUM_SEMS_DEF - 1));
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            act = action_type'($urandom_range(0, 3));
            issue_request(act, idx, pick_count(), PID_W'($urandom));
         end
         3, 4: begin
            // Pile waiters onto one slot; long runs hit the full-queue refusal.
            if ($urandom_range(0, 1)) begin
               issue_request(ACT_DESTROY, idx, COUNT_W'($urandom), PID_W'($urandom));
               issue_request(ACT_CREATE, idx, COUNT_W'($urandom_range(0, 4) - 2),
                             PID_W'($urandom));
            end
            n = $urandom_range(8, 20);
            repeat (n) issue_request(ACT_WAIT, idx, COUNT_W'($urandom), PID_W'($urandom));
            n = $urandom_range(0, 20);
            repeat (n) issue_request(ACT_SIGNAL, idx, COUNT_W'($urandom), PID_W'($urandom));
         end
         5: begin
            n = $urandom_range(4, 20);
            repeat (n) issue_request(ACT_SIGNAL, idx, COUNT_W'($urandom), PID_W'($urandom));
         end
         6: begin
            // Fresh slot near a limit, then a run pushing toward saturation.
            issue_request(ACT_DESTROY, idx, COUNT_W'($urandom), PID_W'($urandom));
            issue_request(ACT_CREATE, idx, pick_count(), PID_W'($urandom));
            act = $urandom_range(0, 1) ? ACT_WAIT : ACT_SIGNAL;
            n = $urandom_range(6, 12);
            repeat (n) issue_request(act, idx, COUNT_W'($urandom), PID_W'($urandom));
         end
         7: begin
            issue_request(ACT_DESTROY, idx, COUNT_W'($urandom), PID_W'($urandom));
         end
         default: begin
            n = $urandom_range(6, 16);
            repeat (n) begin
               if ($urandom_range(0, 7) == 0) begin
                  act = action_type'($urandom_range(0, 1));
               end else begin
                  act = action_type'($urandom_range(2, 3));
               end
               issue_request(act, idx, pick_count(), PID_W'($urandom));
            end
         end
      endcase
   endtask

   initial begin : stimulus
      bit pressure_done;
      int k;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_CREATE;
      req_ch.sem_index = '0;
      req_ch.init_value = '0;
      req_ch.pid = '0;
      pressure_done = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, with light idling on both sides.
      sender_idle_pct = 20;
      sink_idle_pct = 5;
      // Signal, wait and destroy on a slot that was never created.
      issue_request(ACT_SIGNAL, 4'd0, 16'sd0, 8'h00);
      issue_request(ACT_WAIT, 4'd0, 16'sd0, 8'h00);
      issue_request(ACT_DESTROY, 4'd0, 16'sd0, 8'h00);
      // Create at the top limit, a second create on the used slot, then a
      // signal that must saturate and a wait from the highest pid.
      issue_request(ACT_CREATE, 4'd0, 16'sh7fff, 8'h00);
      issue_request(ACT_CREATE, 4'd0, -16'sd5, 8'h00);
      issue_request(ACT_SIGNAL, 4'd0, 16'sd0, 8'h00);
      issue_request(ACT_WAIT, 4'd0, 16'sd0, 8'hff);
      issue_request(ACT_DESTROY, 4'd0, 16'sd0, 8'h00);
      // Create at the bottom limit: the wait saturates and still blocks.
      issue_request(ACT_CREATE, 4'd1, 16'sh8000, 8'h00);
      issue_request(ACT_WAIT, 4'd1, 16'sd0, 8'haa);
      issue_request(ACT_SIGNAL, 4'd1, 16'sd0, 8'h00);
      // Block and wake around zero, then a signal with nobody waiting.
      issue_request(ACT_CREATE, 4'd2, 16'sd0, 8'h00);
      issue_request(ACT_WAIT, 4'd2, 16'sd0, 8'h55);
      issue_request(ACT_SIGNAL, 4'd2, 16'sd0, 8'h00);
      issue_request(ACT_SIGNAL, 4'd2, 16'sd0, 8'h00);
      // Destroy drops the waiter; the recreated slot starts with an empty queue.
      issue_request(ACT_CREATE, 4'd15, 16'sd0, 8'h00);
      issue_request(ACT_WAIT, 4'd15, 16'sd0, 8'h01);
      issue_request(ACT_DESTROY, 4'd15, 16'sd0, 8'h00);
      issue_request(ACT_CREATE, 4'd15, -16'sd1, 8'h00);
      issue_request(ACT_SIGNAL, 4'd15, 16'sd0, 8'h00);
      // A signal leaving the count negative with an empty queue wakes nobody.
      issue_request(ACT_CREATE, 4'd3, -16'sd2, 8'h00);
      issue_request(ACT_SIGNAL, 4'd3, 16'sd0, 8'h00);

      // Random part. Idling settings change from one episode to the next, so
      // some stretches run with no gaps at all.
      while (items_sent < ITEM_TARGET - TAIL_ITEMS) begin
         if (!pressure_done && items_sent >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            sender_idle_pct = 0;
            hold_off_req = 1'b1;
            for (k = 0; k < 24; k++) begin
               issue_request(action_type'($urandom_range(0, 3)), INDEX_W'($urandom),
                             pick_count(), PID_W'($urandom));
            end
         end else begin
            sender_idle_pct = pick_pct(10, 35);
            sink_idle_pct = pick_pct(4, 12);
            run_scenario();
         end
      end

      // Final stretch at full rate on both sides.
      sender_idle_pct = 0;
      sink_idle_pct = 0;
      while (items_sent < ITEM_TARGET) run_scenario();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d create, %0d destroy, %0d wait, %0d signal.",
               items_sent, sent_per_action[ACT_CREATE], sent_per_action[ACT_DESTROY],
               sent_per_action[ACT_WAIT], sent_per_action[ACT_SIGNAL]);
      $display("Checked %0d responses: %0d blocking waits, %0d wakeups, %0d full-queue refusals.",
               checked, blocked_seen, woke_seen, full_seen);
      if (fail_count == 0) begin
         $display("counting_semaphore_table_top: match");
      end else begin
         $display("counting_semaphore_table_top: mismatch");
      end
      $finish;
   end

endmodule
